@@ rtl/led_fd_pkg.sv @@
package led_fd_pkg;

    localparam int MAX_PIXELS   = 256;
    localparam int HEADER_BYTES = 14;
    localparam int POS_MAX      = 1023;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [8:0]  LED_COUNT_RESET   = 9'd256;
    localparam logic [15:0] STALE_TICKS_RESET = 16'd1000;

    typedef enum logic [0:0] {
        CFG_LED_COUNT   = 1'b0,
        CFG_STALE_TICKS = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED     = 3'd0,
        ST_BAD_HEADER   = 3'd1,
        ST_WRONG_COUNT  = 3'd2,
        ST_TOO_SHORT    = 3'd3,
        ST_STALE        = 3'd4,
        ST_STALE_RESYNC = 3'd5
    } status_t;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_TICK   = 1'b1;
    localparam logic RES_PIXEL   = 1'b0;
    localparam logic RES_STATUS  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       end_of_datagram;
    } in_word_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        status_t    status;
        logic       last_of_run;
    } out_word_t;

    // configuration as seen by the parser
    typedef struct packed {
        logic [8:0]  led_count;
        logic [15:0] stale_ticks;
        logic [10:0] min_len;
    } cfg_t;

    // up to two results per accepted word, packed from slot 0
    typedef struct packed {
        logic [1:0] count;
        out_word_t  slot1;
        out_word_t  slot0;
    } push_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h57;
            2'd1:    b = 8'h52;
            2'd2:    b = 8'h47;
            2'd3:    b = 8'h42;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/led_fd_parse.sv @@
module led_fd_parse
    import led_fd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_word_t word,
    input  cfg_t     cfg,
    output push_t    push
);

    logic [9:0]  byte_position_reg, byte_position_next;
    logic        header_ok_reg, header_ok_next;
    logic [15:0] count_shift_reg, count_shift_next;
    logic [63:0] sequence_shift_reg, sequence_shift_next;
    logic [63:0] last_sequence_reg, last_sequence_next;
    logic [15:0] tick_age_reg, tick_age_next;
    logic [15:0] partial_pixel_reg, partial_pixel_next;
    logic [8:0]  pixel_counter_reg, pixel_counter_next;
    logic [1:0]  phase_reg, phase_next;

    logic        emit;
    logic        passed;
    logic        is_last;
    status_t     st;
    out_word_t   pix_word;
    out_word_t   st_word;

    always_comb
    begin
        byte_position_next  = byte_position_reg;
        header_ok_next      = header_ok_reg;
        count_shift_next    = count_shift_reg;
        sequence_shift_next = sequence_shift_reg;
        last_sequence_next  = last_sequence_reg;
        tick_age_next       = tick_age_reg;
        partial_pixel_next  = partial_pixel_reg;
        pixel_counter_next  = pixel_counter_reg;
        phase_next          = phase_reg;
        emit                = 1'b0;
        is_last             = 1'b0;
        st                  = ST_ACCEPTED;
        passed              = header_ok_reg && (count_shift_reg == {7'd0, cfg.led_count});

        if (take && word.kind == KIND_TICK)
        begin
            if (tick_age_reg != 16'hFFFF)
                tick_age_next = tick_age_reg + 16'd1;
        end
        else if (take)
        begin
            if (byte_position_reg < 10'd4)
            begin
                if (word.data_byte != magic_byte(byte_position_reg[1:0]))
                    header_ok_next = 1'b0;
            end
            else if (byte_position_reg < 10'd6)
            begin
                count_shift_next = {word.data_byte, count_shift_reg[15:8]};
            end
            else if (byte_position_reg < 10'(HEADER_BYTES))
            begin
                sequence_shift_next = {word.data_byte, sequence_shift_reg[63:8]};
            end
            else
            begin
                case (phase_reg)
                    2'd0:    partial_pixel_next = {word.data_byte, 8'h00};
                    2'd1:    partial_pixel_next = {partial_pixel_reg[15:8], word.data_byte};
                    default:
                    begin
                        if (passed && pixel_counter_reg < cfg.led_count
                            && pixel_counter_reg < 9'(MAX_PIXELS))
                        begin
                            emit               = 1'b1;
                            pixel_counter_next = pixel_counter_reg + 9'd1;
                        end
                    end
                endcase
            end

            // phase tracks (position - header) mod 3, frozen once position saturates
            if (byte_position_reg < 10'(POS_MAX))
            begin
                byte_position_next = byte_position_reg + 10'd1;
                if (byte_position_reg == 10'(HEADER_BYTES - 1))
                    phase_next = 2'd0;
                else if (byte_position_reg >= 10'(HEADER_BYTES))
                    phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
            end

            if (word.end_of_datagram)
            begin
                is_last = 1'b1;
                if (byte_position_reg < 10'(HEADER_BYTES - 1) || !header_ok_next)
                    st = ST_BAD_HEADER;
                else if (count_shift_next != {7'd0, cfg.led_count})
                    st = ST_WRONG_COUNT;
                else if (({1'b0, byte_position_reg} + 11'd1) < cfg.min_len)
                    st = ST_TOO_SHORT;
                else if (sequence_shift_next <= last_sequence_reg)
                begin
                    if (tick_age_reg > cfg.stale_ticks)
                    begin
                        last_sequence_next = sequence_shift_next;
                        tick_age_next      = 16'd0;
                        st                 = ST_STALE_RESYNC;
                    end
                    else
                        st = ST_STALE;
                end
                else
                begin
                    last_sequence_next = sequence_shift_next;
                    tick_age_next      = 16'd0;
                    st                 = ST_ACCEPTED;
                end

                byte_position_next  = 10'd0;
                header_ok_next      = 1'b1;
                count_shift_next    = 16'd0;
                sequence_shift_next = 64'd0;
                partial_pixel_next  = 16'd0;
                pixel_counter_next  = 9'd0;
                phase_next          = 2'd0;
            end
        end
    end

    always_comb
    begin
        pix_word.result_kind = RES_PIXEL;
        pix_word.pixel_index = pixel_counter_reg[7:0];
        pix_word.red         = partial_pixel_reg[15:8];
        pix_word.green       = partial_pixel_reg[7:0];
        pix_word.blue        = word.data_byte;
        pix_word.status      = ST_ACCEPTED;
        pix_word.last_of_run = !is_last;

        st_word.result_kind  = RES_STATUS;
        st_word.pixel_index  = 8'd0;
        st_word.red          = 8'd0;
        st_word.green        = 8'd0;
        st_word.blue         = 8'd0;
        st_word.status       = st;
        st_word.last_of_run  = 1'b1;

        push.slot0 = emit ? pix_word : st_word;
        push.slot1 = st_word;
        push.count = {1'b0, emit} + {1'b0, is_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg  <= '0;
            header_ok_reg      <= 1'b1;
            count_shift_reg    <= '0;
            sequence_shift_reg <= '0;
            last_sequence_reg  <= '0;
            tick_age_reg       <= '0;
            partial_pixel_reg  <= '0;
            pixel_counter_reg  <= '0;
            phase_reg          <= '0;
        end
        else
        begin
            byte_position_reg  <= byte_position_next;
            header_ok_reg      <= header_ok_next;
            count_shift_reg    <= count_shift_next;
            sequence_shift_reg <= sequence_shift_next;
            last_sequence_reg  <= last_sequence_next;
            tick_age_reg       <= tick_age_next;
            partial_pixel_reg  <= partial_pixel_next;
            pixel_counter_reg  <= pixel_counter_next;
            phase_reg          <= phase_next;
        end
    end

endmodule

@@ rtl/led_fd_out_fifo.sv @@
module led_fd_out_fifo
    import led_fd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    output logic      space_low,
    output logic      valid,
    input  logic      stall,
    output out_word_t word
);

    out_word_t mem [FIFO_DEPTH];

    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;

    assign pop          = valid && !stall;
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    // keep room for a pixel and a status from the same word
    assign space_low = count_reg > FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign valid     = count_reg != '0;
    assign word      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.slot0;
        if (push.count == 2'd2)
            mem[wr_ptr_plus1] <= push.slot1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/led_frame_datagram_deframer.sv @@
// led frame datagram deframer
// byte channel (byte_valid / byte_stall / byte_word): one word per cycle unless
// stalled, a datagram byte (end_of_datagram set on the last) or a single tick event
// result channel (result_valid / result_stall / result_word): tentative pixels as
// each rgb triple completes after a good header, and one frame status per datagram;
// last_of_run marks the final result caused by one input word
// a word is taken whenever byte_valid is high and byte_stall low; its results
// are registered into the queue and follow any earlier results, pixel before status
// throughput is one input word per cycle while byte_stall is low; a word that ends
// a datagram on a pixel byte yields two results, which drain at one per cycle while
// result_stall is low, through a 4-entry queue; byte_stall rises only when that
// queue has fewer than two free entries, so it rises after result_stall, once the
// queue has filled; a stalled result holds its value
// config port: cfg_we with cfg_index 0 sets led_count, 1 sets stale_ticks;
// write only while idle
// reset (rst_n low, async) restores led_count 256, stale_ticks 1000, clears the
// sequence record, tick age and any datagram in progress, and empties the queue
module led_frame_datagram_deframer
    import led_fd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  logic [15:0] cfg_data,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  in_word_t   byte_word,
    output logic       result_valid,
    input  logic       result_stall,
    output out_word_t  result_word
);

    logic [8:0]  led_count_reg, led_count_next;
    logic [15:0] stale_ticks_reg, stale_ticks_next;
    logic [10:0] min_len_reg, min_len_next;

    cfg_t  cfg;
    push_t push;
    logic  take;

    always_comb
    begin
        led_count_next   = led_count_reg;
        stale_ticks_next = stale_ticks_reg;
        min_len_next     = min_len_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LED_COUNT:
                begin
                    led_count_next = cfg_data[8:0];
                    // header plus three bytes per pixel
                    min_len_next   = {2'b00, cfg_data[8:0]} + {1'b0, cfg_data[8:0], 1'b0}
                                     + 11'(HEADER_BYTES);
                end
                CFG_STALE_TICKS: stale_ticks_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg   <= LED_COUNT_RESET;
            stale_ticks_reg <= STALE_TICKS_RESET;
            min_len_reg     <= 11'(3 * 256 + HEADER_BYTES);
        end
        else
        begin
            led_count_reg   <= led_count_next;
            stale_ticks_reg <= stale_ticks_next;
            min_len_reg     <= min_len_next;
        end
    end

    assign cfg.led_count   = led_count_reg;
    assign cfg.stale_ticks = stale_ticks_reg;
    assign cfg.min_len     = min_len_reg;

    assign take = byte_valid && !byte_stall;

    led_fd_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .word  (byte_word),
        .cfg   (cfg),
        .push  (push)
    );

    led_fd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_low (byte_stall),
        .valid     (result_valid),
        .stall     (result_stall),
        .word      (result_word)
    );

endmodule
